### rtl/afu_pkg.sv
package afu_pkg;

    // ROM geometry
    localparam int TBL_N   = 256;
    localparam int ROM_AW  = $clog2(TBL_N + 1);
    localparam int ROM_W   = 17;

    // field and datapath widths
    localparam int X_W       = 16;
    localparam int CFG_W     = 16;
    localparam int ACT_W     = 32;
    localparam int CFG_IDX_W = 3;
    localparam int TANH_W    = 18;
    localparam int MAG_W     = 31;
    localparam int FRAC_SH   = 24;
    localparam int P_W       = MAG_W + ROM_AW;
    localparam int I_W       = P_W - FRAC_SH;
    localparam int RELU_W    = 18;

    // tanh of +-1.0 in Q0.16
    localparam logic signed [TANH_W-1:0] TANH_ONE = TANH_W'(65536);

    // function kinds
    localparam logic [1:0] KIND_RELU    = 2'd0;
    localparam logic [1:0] KIND_SIGMOID = 2'd1;
    localparam logic [1:0] KIND_TANH    = 2'd2;

    // register map
    localparam logic [CFG_IDX_W-1:0] REG_ACT_KIND   = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] REG_DERIV_MODE = CFG_IDX_W'(1);
    localparam logic [CFG_IDX_W-1:0] REG_LEAK       = CFG_IDX_W'(2);
    localparam logic [CFG_IDX_W-1:0] REG_SIG_GAIN   = CFG_IDX_W'(3);
    localparam logic [CFG_IDX_W-1:0] REG_SIG_BOUND  = CFG_IDX_W'(4);
    localparam logic [CFG_IDX_W-1:0] REG_TANH_BOUND = CFG_IDX_W'(5);

    typedef struct packed {
        logic signed [X_W-1:0] sample;
        logic                  last_element;
    } sample_item_t;

    typedef struct packed {
        logic signed [ACT_W-1:0] activation;
        logic                    end_of_vector;
    } result_item_t;

    // advance strobes for the two lookup stages
    typedef struct packed {
        logic lookup;
        logic interp;
    } tanh_en_t;

    typedef logic [ROM_W-1:0] rom_t [TBL_N+1];

    // shift-subtract divide, used only while building the ROM
    function automatic logic [63:0] udiv64(input logic [63:0] num, input logic [63:0] den);
        logic [63:0] q;
        logic [64:0] r;
        q = '0;
        r = '0;
        for (int b = 63; b >= 0; b--)
        begin
            r = {r[63:0], num[b]};
            if (r >= {1'b0, den})
            begin
                r    = r - {1'b0, den};
                q[b] = 1'b1;
            end
        end
        return q;
    endfunction

    // tanh(8k/TBL_N) in Q0.16, built from exp(-16/TBL_N) in Q0.31
    function automatic rom_t build_rom();
        rom_t               rom;
        logic signed [63:0] sum;
        logic [63:0]        term;
        logic [63:0]        d;
        logic [63:0]        e;
        logic [63:0]        one;
        logic [63:0]        num;
        logic [63:0]        den;
        one  = 64'd1 << 31;
        sum  = $signed(one);
        term = one;
        for (int n = 1; n < 64; n++)
        begin
            if (term != 64'd0)
            begin
                term = udiv64(term * 64'd16, 64'(TBL_N) * 64'(n));
                if ((n & 1) != 0)
                    sum = sum - $signed(term);
                else
                    sum = sum + $signed(term);
            end
        end
        d = sum;
        e = one;
        for (int k = 0; k <= TBL_N; k++)
        begin
            num    = (one - e) << 17;
            den    = one + e;
            rom[k] = ROM_W'(udiv64(num + den, den << 1));
            e      = (e * d + (64'd1 << 30)) >> 31;
        end
        return rom;
    endfunction

    localparam rom_t TANH_ROM = build_rom();

endpackage

### rtl/activation_function_unit.sv
// Channel | Dir | Handshake                   | Payload
// sample  | in  | sample_valid / sample_stall | sample_data (sample Q4.12, last_element)
// result  | out | result_valid / result_stall | result_data (activation Q19.12, end_of_vector)
// config  | in  | cfg_write                   | cfg_index, cfg_data
//
// Six register stages: one transaction per cycle while result_stall is low.
// The stages follow the multiplier chain (gain, ROM interpolation, t*t, scale, round).
// Reset clears all stage valid bits and loads the default configuration.
// A stalled result holds the pipe; empty stages still fill, so nothing is dropped.
module activation_function_unit (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                sample_valid,
    output logic                                sample_stall,
    input  afu_pkg::sample_item_t               sample_data,
    output logic                                result_valid,
    input  logic                                result_stall,
    output afu_pkg::result_item_t               result_data,
    input  logic                                cfg_write,
    input  logic [afu_pkg::CFG_IDX_W-1:0]       cfg_index,
    input  logic [afu_pkg::CFG_W-1:0]           cfg_data
);
    import afu_pkg::*;

    // configuration
    logic [1:0]                act_kind_reg;
    logic                      deriv_reg;
    logic [CFG_W-1:0]          leak_reg;
    logic signed [CFG_W-1:0]   gain_reg;
    logic signed [CFG_W-1:0]   sbound_reg;
    logic signed [CFG_W-1:0]   tbound_reg;
    logic signed [31:0]        bg_reg;

    // stage enables and valids
    logic en1, en2, en3, en4, en5, en6;
    logic v1_reg, v2_reg, v3_reg, v4_reg, v5_reg, out_v_reg;

    // stage 1
    logic signed [16:0]        opa1;
    logic signed [32:0]        mul1;
    logic signed [X_W-1:0]     s1_x_reg;
    logic signed [32:0]        s1_prod_reg;
    logic                      s1_last_reg;

    // stage 2
    logic signed [31:0]        tanh_arg;
    logic signed [33:0]        relu_rnd;
    logic [16:0]               leak_rnd;
    logic                      x_pos;
    logic signed [RELU_W-1:0]  relu_next;
    logic signed [RELU_W-1:0]  s2_relu_reg;
    logic                      s2_last_reg;
    tanh_en_t                  tanh_adv;

    // stage 3
    logic signed [TANH_W-1:0]  tanh_val;
    logic signed [RELU_W-1:0]  s3_relu_reg;
    logic                      s3_last_reg;

    // stage 4
    logic signed [35:0]        t_sq;
    logic signed [36:0]        omt_full;
    logic signed [18:0]        fwd_m;
    logic signed [33:0]        opb_next;
    logic signed [33:0]        s4_opb_reg;
    logic signed [RELU_W-1:0]  s4_relu_reg;
    logic                      s4_last_reg;

    // stage 5
    logic signed [31:0]        opa5;
    logic signed [65:0]        mul5;
    logic signed [65:0]        s5_prod_reg;
    logic signed [RELU_W-1:0]  s5_relu_reg;
    logic                      s5_last_reg;

    // stage 6
    logic signed [66:0]        prod_x;
    logic signed [66:0]        rnd_val;
    logic signed [ACT_W-1:0]   sat_val;
    logic signed [ACT_W-1:0]   act_next;
    logic signed [ACT_W-1:0]   out_act_reg;
    logic                      out_last_reg;

    // ---------------- configuration ----------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            act_kind_reg <= KIND_RELU;
            deriv_reg    <= 1'b0;
            leak_reg     <= '0;
            gain_reg     <= CFG_W'(256);
            sbound_reg   <= CFG_W'(256);
            tbound_reg   <= CFG_W'(256);
        end
        else if (cfg_write)
        begin
            unique case (cfg_index)
                REG_ACT_KIND:   act_kind_reg <= cfg_data[1:0];
                REG_DERIV_MODE: deriv_reg    <= cfg_data[0];
                REG_LEAK:       leak_reg     <= cfg_data;
                REG_SIG_GAIN:   gain_reg     <= cfg_data;
                REG_SIG_BOUND:  sbound_reg   <= cfg_data;
                REG_TANH_BOUND: tbound_reg   <= cfg_data;
                default: ;
            endcase
        end
    end

    // bound*gain for the sigmoid slope, follows the registers
    always_ff @(posedge clk)
    begin
        bg_reg <= 32'(gain_reg) * 32'(sbound_reg);
    end

    // ---------------- flow control ----------------
    assign en6 = !out_v_reg || !result_stall;
    assign en5 = !v5_reg || en6;
    assign en4 = !v4_reg || en5;
    assign en3 = !v3_reg || en4;
    assign en2 = !v2_reg || en3;
    assign en1 = !v1_reg || en2;
    assign sample_stall = !en1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg    <= 1'b0;
            v2_reg    <= 1'b0;
            v3_reg    <= 1'b0;
            v4_reg    <= 1'b0;
            v5_reg    <= 1'b0;
            out_v_reg <= 1'b0;
        end
        else
        begin
            if (en1) v1_reg    <= sample_valid;
            if (en2) v2_reg    <= v1_reg;
            if (en3) v3_reg    <= v2_reg;
            if (en4) v4_reg    <= v3_reg;
            if (en5) v5_reg    <= v4_reg;
            if (en6) out_v_reg <= v5_reg;
        end
    end

    // ---------------- stage 1: gain or leak product ----------------
    assign opa1 = (act_kind_reg == KIND_RELU) ? $signed({1'b0, leak_reg}) : 17'(gain_reg);
    assign mul1 = 33'(opa1) * 33'(sample_data.sample);

    always_ff @(posedge clk)
    begin
        if (en1)
        begin
            s1_x_reg    <= sample_data.sample;
            s1_prod_reg <= mul1;
            s1_last_reg <= sample_data.last_element;
        end
    end

    // ---------------- stage 2: relu, tanh table lookup ----------------
    // tanh input moved to 21 fraction bits so both functions share one table
    assign tanh_arg = (act_kind_reg == KIND_TANH) ? {{7{s1_x_reg[15]}}, s1_x_reg, 9'b0}
                                                 : s1_prod_reg[31:0];

    assign relu_rnd = 34'(s1_prod_reg) + 34'sd32768;
    assign leak_rnd = 17'(leak_reg) + 17'd8;
    assign x_pos    = s1_x_reg > 16'sd0;

    always_comb
    begin
        if (deriv_reg)
            relu_next = x_pos ? RELU_W'(4096) : RELU_W'($signed({1'b0, leak_rnd[16:4]}));
        else
            relu_next = x_pos ? RELU_W'(s1_x_reg) : relu_rnd[33:16];
    end

    always_ff @(posedge clk)
    begin
        if (en2)
        begin
            s2_relu_reg <= relu_next;
            s2_last_reg <= s1_last_reg;
        end
    end

    assign tanh_adv = '{lookup: en2, interp: en3};

    afu_tanh u_tanh (
        .clk      (clk),
        .adv      (tanh_adv),
        .arg      (tanh_arg),
        .tanh_val (tanh_val)
    );

    // ---------------- stage 3: sideband alongside interpolation ----------------
    always_ff @(posedge clk)
    begin
        if (en3)
        begin
            s3_relu_reg <= s2_relu_reg;
            s3_last_reg <= s2_last_reg;
        end
    end

    // ---------------- stage 4: 1 - t^2 or forward operand ----------------
    assign t_sq     = 36'(tanh_val) * 36'(tanh_val);
    assign omt_full = 37'sd4294967296 - 37'(t_sq);
    assign fwd_m    = (act_kind_reg == KIND_SIGMOID) ? 19'(tanh_val) + 19'sd65536
                                                     : 19'(tanh_val);
    assign opb_next = deriv_reg ? $signed({1'b0, omt_full[32:0]}) : 34'(fwd_m);

    always_ff @(posedge clk)
    begin
        if (en4)
        begin
            s4_opb_reg  <= opb_next;
            s4_relu_reg <= s3_relu_reg;
            s4_last_reg <= s3_last_reg;
        end
    end

    // ---------------- stage 5: scale by bound ----------------
    always_comb
    begin
        if (deriv_reg)
            opa5 = (act_kind_reg == KIND_TANH) ? 32'(tbound_reg) : bg_reg;
        else
            opa5 = (act_kind_reg == KIND_SIGMOID) ? 32'(sbound_reg) : 32'(tbound_reg);
    end

    assign mul5 = 66'(opa5) * 66'(s4_opb_reg);

    always_ff @(posedge clk)
    begin
        if (en5)
        begin
            s5_prod_reg <= mul5;
            s5_relu_reg <= s4_relu_reg;
            s5_last_reg <= s4_last_reg;
        end
    end

    // ---------------- stage 6: round, saturate, select ----------------
    assign prod_x = 67'(s5_prod_reg);

    always_comb
    begin
        if (act_kind_reg == KIND_SIGMOID)
            rnd_val = deriv_reg ? (prod_x + (67'sd1 <<< 37)) >>> 38
                                : (prod_x + (67'sd1 <<< 12)) >>> 13;
        else
            rnd_val = deriv_reg ? (prod_x + (67'sd1 <<< 27)) >>> 28
                                : (prod_x + (67'sd1 <<< 11)) >>> 12;
    end

    always_comb
    begin
        if (rnd_val > 67'sd2147483647)
            sat_val = 32'sh7FFF_FFFF;
        else if (rnd_val < -67'sd2147483648)
            sat_val = 32'sh8000_0000;
        else
            sat_val = rnd_val[31:0];
    end

    always_comb
    begin
        case (act_kind_reg)
            KIND_RELU:    act_next = ACT_W'(s5_relu_reg);
            KIND_SIGMOID: act_next = sat_val;
            KIND_TANH:    act_next = sat_val;
            default:      act_next = '0;
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (en6)
        begin
            out_act_reg  <= act_next;
            out_last_reg <= s5_last_reg;
        end
    end

    assign result_valid = out_v_reg;
    assign result_data  = '{activation: out_act_reg, end_of_vector: out_last_reg};

`ifndef SYNTHESIS
    // input is held off only when every stage is occupied
    a_stall_full: assert property (@(posedge clk) disable iff (!rst_n)
        sample_stall |-> (v1_reg && v2_reg && v3_reg && v4_reg && v5_reg && out_v_reg))
        else $error("input stalled with a bubble in the pipe");

    a_accept_enters: assert property (@(posedge clk) disable iff (!rst_n)
        (sample_valid && !sample_stall) |=> v1_reg)
        else $error("accepted transaction missing from stage 1");

    a_tail_moves: assert property (@(posedge clk) disable iff (!rst_n)
        (v5_reg && en6) |=> result_valid)
        else $error("transaction lost at output register");

    a_tanh_range: assert property (@(posedge clk) disable iff (!rst_n)
        v3_reg |-> (tanh_val <= TANH_ONE && tanh_val >= -TANH_ONE))
        else $error("interpolated tanh out of range");
`endif

endmodule

### rtl/afu_tanh.sv
module afu_tanh (
    input  logic                                clk,
    input  afu_pkg::tanh_en_t                   adv,
    input  logic signed [31:0]                  arg,
    output logic signed [afu_pkg::TANH_W-1:0]   tanh_val
);
    import afu_pkg::*;

    localparam int IP_W = ROM_W + FRAC_SH + 1;
    localparam int ST_W = IP_W - FRAC_SH;

    logic                 neg;
    logic [MAG_W-1:0]     mag;
    logic [P_W-1:0]       pos;
    logic [I_W-1:0]       seg;
    logic                 sat;
    logic [ROM_AW-1:0]    idx;
    logic [ROM_W-1:0]     lo;
    logic [ROM_W-1:0]     hi;

    logic                 a_neg_reg;
    logic                 a_sat_reg;
    logic [ROM_W-1:0]     a_lo_reg;
    logic [ROM_W-1:0]     a_diff_reg;
    logic [FRAC_SH-1:0]   a_frac_reg;

    logic [IP_W-1:0]      ip;
    logic [ST_W-1:0]      step;
    logic [TANH_W-1:0]    v;
    logic signed [TANH_W-1:0] t_next;
    logic signed [TANH_W-1:0] b_t_reg;

    // lookup: table position is |arg| * TBL_N with 24 fraction bits
    assign neg = arg[31];
    assign mag = neg ? MAG_W'(-arg) : MAG_W'(arg);
    assign pos = P_W'(mag) * P_W'(TBL_N);
    assign seg = pos[P_W-1:FRAC_SH];
    assign sat = seg >= I_W'(TBL_N);
    assign idx = sat ? '0 : seg[ROM_AW-1:0];
    assign lo  = TANH_ROM[idx];
    assign hi  = TANH_ROM[idx + ROM_AW'(1)];

    always_ff @(posedge clk)
    begin
        if (adv.lookup)
        begin
            a_neg_reg  <= neg;
            a_sat_reg  <= sat;
            a_lo_reg   <= lo;
            a_diff_reg <= (hi > lo) ? hi - lo : '0;
            a_frac_reg <= pos[FRAC_SH-1:0];
        end
    end

    // interpolate, round half up
    assign ip   = IP_W'(a_diff_reg) * IP_W'(a_frac_reg) + (IP_W'(1) << (FRAC_SH - 1));
    assign step = ip[IP_W-1:FRAC_SH];
    assign v    = a_sat_reg ? TANH_ONE : TANH_W'(a_lo_reg) + TANH_W'(step);
    assign t_next = a_neg_reg ? -$signed(v) : $signed(v);

    always_ff @(posedge clk)
    begin
        if (adv.interp)
            b_t_reg <= t_next;
    end

    assign tanh_val = b_t_reg;

endmodule

### test/activation_function_unit_test.sv
`timescale 1ns / 1ps

module activation_function_unit_test;

    import afu_pkg::*;

    localparam logic [1:0] KIND_UNUSED = 2'd3;

    // indexes past the register map, writes there must be dropped
    localparam logic [CFG_IDX_W-1:0] REG_SPARE_A = CFG_IDX_W'(6);
    localparam logic [CFG_IDX_W-1:0] REG_SPARE_B = CFG_IDX_W'(7);

    localparam logic [5:0] M_NONE   = 6'b0;
    localparam logic [5:0] M_KIND   = 6'b1 << REG_ACT_KIND;
    localparam logic [5:0] M_DERIV  = 6'b1 << REG_DERIV_MODE;
    localparam logic [5:0] M_LEAK   = 6'b1 << REG_LEAK;
    localparam logic [5:0] M_GAIN   = 6'b1 << REG_SIG_GAIN;
    localparam logic [5:0] M_SBOUND = 6'b1 << REG_SIG_BOUND;
    localparam logic [5:0] M_TBOUND = 6'b1 << REG_TANH_BOUND;
    localparam logic [5:0] M_ALL    = 6'b111111;

    localparam logic signed [63:0] ONE_Q32 = 64'sd1 <<< 32;

    localparam int RANDOM_PHASES   = 14;
    localparam int ITEMS_PER_PHASE = 80;
    localparam int PRESSURE_PHASE  = 2;
    localparam int LONG_HOLD       = 150;
    localparam int WATCHDOG_LIMIT  = 4000;
    localparam int DRAIN_CYCLES    = 12;

    typedef struct packed {
        logic [5:0]         mask;
        logic [15:0]        kind;
        logic [15:0]        deriv;
        logic [15:0]        leak;
        logic [15:0]        gain;
        logic [15:0]        sbound;
        logic [15:0]        tbound;
        logic [15:0]        sample;
        logic               last;
        logic               typed;
        logic signed [31:0] value;
    } stim_row_t;

    logic         clk;
    logic         rst_n;
    logic         sample_valid;
    logic         sample_stall;
    sample_item_t sample_data;
    logic         result_valid;
    logic         result_stall;
    result_item_t result_data;
    logic         cfg_write;
    logic [CFG_IDX_W-1:0] cfg_index;
    logic [CFG_W-1:0]     cfg_data;

    // shadow copy of the register file
    logic [1:0]  kind_q   = KIND_RELU;
    logic        deriv_q  = 1'b0;
    logic [15:0] leak_q   = 16'h0000;
    logic [15:0] gain_q   = 16'h0100;
    logic [15:0] sbound_q = 16'h0100;
    logic [15:0] tbound_q = 16'h0100;

    logic [63:0] tanh_table [0:TBL_N];

    result_item_t pending_activations [$];
    result_item_t want_result;

    logic sink_steady    = 1'b0;
    logic source_steady  = 1'b0;
    logic sink_long_hold = 1'b0;

    int samples_accepted = 0;
    int results_seen     = 0;
    int settings_applied = 0;
    int mismatch_count   = 0;
    int idle_cycles      = 0;

    stim_row_t directed_rows [24] = '{
        // reset defaults: relu forward, zero leak
        '{M_NONE, 0, 0, 0, 0, 0, 0, 'h7fff, 0, 1, 32767},
        '{M_NONE, 0, 0, 0, 0, 0, 0, 'h8000, 1, 1, 0},
        '{M_NONE, 0, 0, 0, 0, 0, 0, 'h0000, 0, 1, 0},
        '{M_DERIV, 0, 1, 0, 0, 0, 0, 'h0001, 0, 1, 4096},
        '{M_NONE, 0, 0, 0, 0, 0, 0, 'h8000, 1, 1, 0},
        '{M_LEAK, 0, 0, 'hffff, 0, 0, 0, 'h8000, 0, 1, 4096},
        '{M_DERIV, 0, 0, 0, 0, 0, 0, 'h8000, 0, 1, -32767},
        '{M_NONE, 0, 0, 0, 0, 0, 0, 'hffff, 1, 0, 0},
        // unused kind gives zero
        '{M_KIND, KIND_UNUSED, 0, 0, 0, 0, 0, 'h1234, 0, 1, 0},
        '{M_DERIV, 0, 1, 0, 0, 0, 0, 'h8000, 1, 1, 0},
        '{M_KIND | M_DERIV, KIND_TANH, 0, 0, 0, 0, 0, 'h0000, 0, 1, 0},
        // -8.0 is past the ROM, tanh is exactly -1
        '{M_NONE, 0, 0, 0, 0, 0, 0, 'h8000, 0, 1, -4096},
        '{M_NONE, 0, 0, 0, 0, 0, 0, 'h7fff, 1, 0, 0},
        '{M_NONE, 0, 0, 0, 0, 0, 0, 'h1000, 0, 0, 0},
        '{M_DERIV, 0, 1, 0, 0, 0, 0, 'h0000, 0, 1, 4096},
        '{M_NONE, 0, 0, 0, 0, 0, 0, 'h8000, 1, 1, 0},
        '{M_DERIV | M_TBOUND, 0, 0, 0, 0, 0, 'h8000, 'h8000, 0, 1, 524288},
        // high bits of the narrow registers are dropped
        '{M_KIND, {14'h3fff, KIND_SIGMOID}, 0, 0, 0, 0, 0, 'h0000, 0, 1, 2048},
        '{M_DERIV, 0, 'hffff, 0, 0, 0, 0, 'h0000, 1, 1, 1024},
        '{M_DERIV | M_GAIN | M_SBOUND, 0, 'hfffe, 0, 'h8000, 'h8000, 0, 'h8000, 0, 1, -524288},
        '{M_DERIV, 0, 1, 0, 0, 0, 0, 'h8000, 1, 1, 0},
        '{M_GAIN, 0, 0, 0, 'h7fff, 0, 0, 'h7fff, 0, 0, 0},
        '{M_DERIV | M_GAIN | M_SBOUND, 0, 0, 0, 'h0180, 'h7fff, 0, 'hc000, 1, 0, 0},
        '{M_KIND | M_LEAK, KIND_RELU, 0, 'h8000, 0, 0, 0, 'h8001, 0, 0, 0}
    };

    activation_function_unit dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .sample_valid (sample_valid),
        .sample_stall (sample_stall),
        .sample_data  (sample_data),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .result_data  (result_data),
        .cfg_write    (cfg_write),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data)
    );

    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    // tanh(8k/N) in Q0.16 from a Q0.31 series for exp(-16/N)
    function automatic void build_tanh_table();
        logic [63:0] decay;
        logic [63:0] term;
        logic [63:0] e;
        logic [63:0] unity;
        logic [63:0] num;
        logic [63:0] den;
        unity = 64'd1 << 31;
        decay = unity;
        term  = unity;
        for (int n = 1; n < 64 && term != 64'd0; n++)
        begin
            term = term * 64'd16 / (64'(TBL_N) * 64'(n));
            if (n % 2 == 1)
                decay = decay - term;
            else
                decay = decay + term;
        end
        e = unity;
        for (int k = 0; k <= TBL_N; k++)
        begin
            num           = (unity - e) << 17;
            den           = unity + e;
            tanh_table[k] = (num + den) / (den * 64'd2);
            e             = (e * decay + (64'd1 << 30)) >> 31;
        end
    endfunction

    function automatic logic signed [63:0] round_shift(input logic signed [63:0] v, input int s);
        return (v + (64'sd1 <<< (s - 1))) >>> s;
    endfunction

    function automatic logic signed [63:0] tanh_lookup(input logic signed [63:0] u,
                                                        input int frac_bits);
        logic [63:0] a;
        logic [63:0] p;
        logic [63:0] idx;
        logic [63:0] f;
        logic [63:0] lo;
        logic [63:0] hi;
        logic [63:0] diff;
        logic [63:0] v;
        int          sh;
        a   = (u < 0) ? -u : u;
        p   = a * 64'(TBL_N);
        sh  = frac_bits + 3;
        idx = p >> sh;
        if (idx >= 64'(TBL_N))
            v = 64'd65536;
        else
        begin
            f    = p & ((64'd1 << sh) - 64'd1);
            lo   = tanh_table[idx];
            hi   = tanh_table[idx + 1];
            diff = (hi > lo) ? hi - lo : 64'd0;
            v    = lo + ((diff * f + (64'd1 << (sh - 1))) >> sh);
        end
        return (u < 0) ? -$signed(v) : $signed(v);
    endfunction

    function automatic result_item_t predict_activation(input sample_item_t item);
        logic signed [63:0] x;
        logic signed [63:0] w;
        logic signed [63:0] g;
        logic signed [63:0] b;
        logic signed [63:0] t;
        logic signed [63:0] r;
        result_item_t       res;
        x = {{48{item.sample[15]}}, item.sample};
        w = {48'd0, leak_q};
        g = {{48{gain_q[15]}}, gain_q};
        r = 64'sd0;
        case (kind_q)
            KIND_RELU:
            begin
                if (deriv_q)
                    r = (x > 0) ? 64'sd4096 : round_shift(w, 4);
                else
                    r = (x > 0) ? x : round_shift(w * x, 16);
            end
            KIND_SIGMOID:
            begin
                // sigmoid through tanh of half the scaled argument
                b = {{48{sbound_q[15]}}, sbound_q};
                t = tanh_lookup(g * x, 21);
                if (deriv_q)
                    r = round_shift(b * g * (ONE_Q32 - t * t), 38);
                else
                    r = round_shift(b * (64'sd65536 + t), 13);
            end
            KIND_TANH:
            begin
                b = {{48{tbound_q[15]}}, tbound_q};
                t = tanh_lookup(x, 12);
                if (deriv_q)
                    r = round_shift(b * (ONE_Q32 - t * t), 28);
                else
                    r = round_shift(b * t, 12);
            end
            default:
                r = 64'sd0;
        endcase
        if (r > 64'sd2147483647)
            r = 64'sd2147483647;
        else if (r < -64'sd2147483648)
            r = -64'sd2147483648;
        res.activation    = r[31:0];
        res.end_of_vector = item.last_element;
        return res;
    endfunction

    task automatic wait_idle();
        while (pending_activations.size() != 0)
            @(posedge clk);
    endtask

    task automatic write_register(input logic [CFG_IDX_W-1:0] idx, input logic [15:0] data);
        cfg_write <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        @(posedge clk);
        case (idx)
            REG_ACT_KIND:   kind_q   = data[1:0];
            REG_DERIV_MODE: deriv_q  = data[0];
            REG_LEAK:       leak_q   = data;
            REG_SIG_GAIN:   gain_q   = data;
            REG_SIG_BOUND:  sbound_q = data;
            REG_TANH_BOUND: tbound_q = data;
            default:        ;
        endcase
    endtask

    task automatic program_unit(input logic [5:0] mask, input logic [15:0] kind,
                                input logic [15:0] deriv, input logic [15:0] leak,
                                input logic [15:0] gain, input logic [15:0] sbound,
                                input logic [15:0] tbound);
        wait_idle();
        if (mask != M_NONE)
        begin
            if (mask[REG_ACT_KIND])
                write_register(REG_ACT_KIND, kind);
            if (mask[REG_DERIV_MODE])
                write_register(REG_DERIV_MODE, deriv);
            if (mask[REG_LEAK])
                write_register(REG_LEAK, leak);
            if (mask[REG_SIG_GAIN])
                write_register(REG_SIG_GAIN, gain);
            if (mask[REG_SIG_BOUND])
                write_register(REG_SIG_BOUND, sbound);
            if (mask[REG_TANH_BOUND])
                write_register(REG_TANH_BOUND, tbound);
            if (mask == M_ALL)
            begin
                write_register(REG_SPARE_A, 16'($urandom));
                write_register(REG_SPARE_B, 16'($urandom));
            end
            cfg_write <= 1'b0;
            settings_applied++;
        end
    endtask

    task automatic send_item(input sample_item_t item, input int gap, input result_item_t want);
        if (gap > 0)
        begin
            sample_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        sample_valid <= 1'b1;
        sample_data  <= item;
        do
            @(posedge clk);
        while (!(sample_valid && !sample_stall));
        pending_activations.push_back(want);
        samples_accepted++;
    endtask

    function automatic logic [15:0] pick_word();
        case ($urandom_range(0, 7))
            0:       return 16'h0000;
            1:       return 16'hffff;
            2:       return 16'h8000;
            3:       return 16'h7fff;
            4:       return 16'h0100;
            default: return 16'($urandom);
        endcase
    endfunction

    initial
    begin : result_sink
        int gap;
        result_stall = 1'b0;
        do
            @(posedge clk);
        while (!rst_n);
        forever
        begin
            gap = sink_steady ? 0 : $urandom_range(0, 14);
            if (sink_long_hold)
            begin
                gap            = LONG_HOLD;
                sink_long_hold = 1'b0;
            end
            if (gap > 0)
            begin
                result_stall <= 1'b1;
                repeat (gap) @(posedge clk);
            end
            result_stall <= 1'b0;
            do
                @(posedge clk);
            while (!(result_valid && !result_stall));
        end
    end

    always @(posedge clk)
    begin
        if (rst_n && result_valid && !result_stall)
        begin
            results_seen++;
            if (pending_activations.size() == 0)
            begin
                $error("unexpected transaction: activation %0d", result_data.activation);
                mismatch_count++;
            end
            else
            begin
                want_result = pending_activations.pop_front();
                if (result_data.activation !== want_result.activation)
                begin
                    $error("activation: expected %0d, got %0d",
                           want_result.activation, result_data.activation);
                    mismatch_count++;
                end
                if (result_data.end_of_vector !== want_result.end_of_vector)
                begin
                    $error("end_of_vector: expected %0b, got %0b",
                           want_result.end_of_vector, result_data.end_of_vector);
                    mismatch_count++;
                end
            end
        end
    end

    always @(posedge clk)
    begin
        if (!rst_n || (sample_valid && !sample_stall) || (result_valid && !result_stall)
            || cfg_write)
            idle_cycles <= 0;
        else if (idle_cycles >= WATCHDOG_LIMIT)
        begin
            $display("watchdog: no transaction for %0d cycles", idle_cycles);
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
        else
            idle_cycles <= idle_cycles + 1;
    end

    initial
    begin : stimulus
        stim_row_t    row;
        sample_item_t item;
        result_item_t want;
        logic [1:0]   kind;
        logic [15:0]  gain;
        build_tanh_table();
        rst_n        = 1'b0;
        sample_valid = 1'b0;
        sample_data  = '0;
        cfg_write    = 1'b0;
        cfg_index    = '0;
        cfg_data     = '0;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (directed_rows[r])
        begin
            row = directed_rows[r];
            program_unit(row.mask, row.kind, row.deriv, row.leak, row.gain, row.sbound,
                         row.tbound);
            item.sample       = row.sample;
            item.last_element = row.last;
            want              = predict_activation(item);
            if (row.typed)
                want.activation = row.value;
            send_item(item, $urandom_range(0, 14), want);
            sample_valid <= 1'b0;
        end

        for (int phase = 0; phase < RANDOM_PHASES; phase++)
        begin
            case ($urandom_range(0, 9))
                0, 1, 2: kind = KIND_RELU;
                3, 4, 5: kind = KIND_SIGMOID;
                6, 7, 8: kind = KIND_TANH;
                default: kind = KIND_UNUSED;
            endcase
            // small gains keep the sigmoid off its rails
            if (kind == KIND_SIGMOID && $urandom_range(0, 1) == 1)
                gain = 16'($urandom_range(0, 1024) - 512);
            else
                gain = pick_word();
            source_steady = ($urandom_range(0, 3) == 0);
            sink_steady   = ($urandom_range(0, 3) == 0);
            program_unit(M_ALL, {14'($urandom), kind}, 16'($urandom), pick_word(), gain,
                         pick_word(), pick_word());
            if (phase == PRESSURE_PHASE)
            begin
                // sink holds off while the source runs flat out
                source_steady  = 1'b1;
                sink_steady    = 1'b0;
                sink_long_hold = 1'b1;
            end
            for (int n = 0; n < ITEMS_PER_PHASE; n++)
            begin
                case ($urandom_range(0, 7))
                    0:       item.sample = 16'h8000;
                    1:       item.sample = 16'h7fff;
                    2:       item.sample = 16'($urandom_range(0, 2) - 1);
                    3, 4, 5: item.sample = 16'($urandom_range(0, 16383) - 8192);
                    default: item.sample = 16'($urandom);
                endcase
                item.last_element = ($urandom_range(0, 7) == 0);
                send_item(item, source_steady ? 0 : $urandom_range(0, 14),
                          predict_activation(item));
            end
            sample_valid <= 1'b0;
        end

        wait_idle();
        repeat (DRAIN_CYCLES) @(posedge clk);
        $display("%0d samples over %0d register settings, all function kinds and modes",
                 samples_accepted, settings_applied);
        $display("%0d results compared, %0d mismatches", results_seen, mismatch_count);
        if (mismatch_count == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule

### activation_function_unit.f
rtl/afu_pkg.sv
rtl/afu_tanh.sv
rtl/activation_function_unit.sv
test/activation_function_unit_test.sv
